/* sv/dxt1_pkg.sv */
// shared types and constants of the dxt1 block texel decoder
package dxt1_pkg;

	localparam int unsigned ROWS      = 4;
	localparam int unsigned COLS      = 4;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned TEXEL_W   = 32;
	localparam int unsigned IDX_W     = 2;
	localparam int unsigned ROW_BITS  = 8;
	localparam int unsigned ROW_NUM_W = 2;

	localparam logic [ROW_NUM_W-1:0] LAST_ROW = 2'd3;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

	typedef logic [TEXEL_W-1:0] texel_t;
	typedef logic [ROW_BITS-1:0] row_idx_t;

	// one decoded block: palette and the four row index bytes
	typedef struct packed {
		texel_t   [3:0] pal;
		row_idx_t [3:0] idx;
	} block_t;

endpackage

/* sv/dxt1_block_texel_decoder.sv */
// top level of the dxt1 block texel decoder
//
// channel   direction  handshake          word
// block     in         start, busy        first_color, second_color, row_*_indices
// row       out        strobe             row_number, texel_*, last_row
//
// one block gives four row words, one per cycle while the queue is not empty; the pace is
// set by the row counter of the back part, which reads one queue entry a row at a time
// first row word passes front stage, queue and output register; the rest follow back to back
// arst_n clears the front stage, the queue and the row counter; no word is shown after reset
// busy is raised only while the front stage holds a block and the queue is full

module dxt1_block_texel_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] first_color,
	input  logic [15:0] second_color,
	input  logic [7:0]  row_zero_indices,
	input  logic [7:0]  row_one_indices,
	input  logic [7:0]  row_two_indices,
	input  logic [7:0]  row_three_indices,
	output logic        strobe,
	output logic [1:0]  row_number,
	output logic [31:0] texel_left,
	output logic [31:0] texel_second,
	output logic [31:0] texel_third,
	output logic [31:0] texel_right,
	output logic        last_row
);

	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	dxt1_pkg::block_t push_word;
	dxt1_pkg::block_t head_word;

	dxt1_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.first_color       (first_color),
		.second_color      (second_color),
		.row_zero_indices  (row_zero_indices),
		.row_one_indices   (row_one_indices),
		.row_two_indices   (row_two_indices),
		.row_three_indices (row_three_indices),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_word            (push_word)
	);

	dxt1_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.pop       (q_pop),
		.head_word (head_word),
		.full      (q_full),
		.empty     (q_empty)
	);

	dxt1_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_word    (head_word),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.strobe       (strobe),
		.row_number   (row_number),
		.texel_left   (texel_left),
		.texel_second (texel_second),
		.texel_third  (texel_third),
		.texel_right  (texel_right),
		.last_row     (last_row)
	);

endmodule

/* sv/dxt1_front.sv */
// front part: accepts a block, builds its four-entry palette and hands it to the queue
module dxt1_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [15:0]            first_color,
	input  logic [15:0]            second_color,
	input  logic [7:0]             row_zero_indices,
	input  logic [7:0]             row_one_indices,
	input  logic [7:0]             row_two_indices,
	input  logic [7:0]             row_three_indices,
	input  logic                   q_full,
	output logic                   q_push,
	output dxt1_pkg::block_t       q_word
);

	logic               valid_s1;
	dxt1_pkg::block_t   word_s1;
	dxt1_pkg::block_t   word_d;
	logic               accept;
	logic [7:0]         r0, g0, b0, r1, g1, b1;
	logic [23:0]        mid_r, mid_g, mid_b;
	logic               greater;

	// returns {entry 2, entry 3, average} for one channel
	function automatic logic [23:0] chan_mix(input logic [7:0] e0, input logic [7:0] e1);
		logic signed [9:0] d;
		logic signed [9:0] k;
		logic signed [9:0] p2;
		logic signed [9:0] p3;
		logic [8:0]        sum;
		d   = signed'({2'b00, e1}) - signed'({2'b00, e0});
		k   = (d >>> 1) - (d >>> 3);
		p2  = signed'({2'b00, e0}) + k;
		p3  = signed'({2'b00, e1}) - k;
		sum = {1'b0, e0} + {1'b0, e1} + 9'd1;
		return {p2[7:0], p3[7:0], sum[8:1]};
	endfunction

	assign accept = start & ~busy;
	assign busy   = valid_s1 & q_full;
	assign q_push = valid_s1 & ~q_full;
	assign q_word = word_s1;

	always_comb begin
		r0 = {first_color[15:11], first_color[15:13]};
		g0 = {first_color[10:5], first_color[10:9]};
		b0 = {first_color[4:0], first_color[4:2]};
		r1 = {second_color[15:11], second_color[15:13]};
		g1 = {second_color[10:5], second_color[10:9]};
		b1 = {second_color[4:0], second_color[4:2]};
		mid_r = chan_mix(r0, r1);
		mid_g = chan_mix(g0, g1);
		mid_b = chan_mix(b0, b1);
		greater = first_color > second_color;
		word_d.pal[0] = {dxt1_pkg::ALPHA_OPAQUE, r0, g0, b0};
		word_d.pal[1] = {dxt1_pkg::ALPHA_OPAQUE, r1, g1, b1};
		if (greater) begin
			word_d.pal[2] = {dxt1_pkg::ALPHA_OPAQUE, mid_r[23:16], mid_g[23:16], mid_b[23:16]};
			word_d.pal[3] = {dxt1_pkg::ALPHA_OPAQUE, mid_r[15:8], mid_g[15:8], mid_b[15:8]};
		end else begin
			word_d.pal[2] = {dxt1_pkg::ALPHA_OPAQUE, mid_r[7:0], mid_g[7:0], mid_b[7:0]};
			word_d.pal[3] = {dxt1_pkg::ALPHA_CLEAR, r1, g1, b1};
		end
		word_d.idx[0] = row_zero_indices;
		word_d.idx[1] = row_one_indices;
		word_d.idx[2] = row_two_indices;
		word_d.idx[3] = row_three_indices;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= word_d;
		end
	end

endmodule

/* sv/dxt1_queue.sv */
// short queue of decoded blocks between the front and back parts
module dxt1_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dxt1_pkg::block_t push_word,
	input  logic             pop,
	output dxt1_pkg::block_t head_word,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dxt1_pkg::block_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* sv/dxt1_back.sv */
// back part: walks the four rows of the head block and drives one row word per cycle while the queue is not empty
module dxt1_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dxt1_pkg::block_t head_word,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             strobe,
	output logic [1:0]       row_number,
	output logic [31:0]      texel_left,
	output logic [31:0]      texel_second,
	output logic [31:0]      texel_third,
	output logic [31:0]      texel_right,
	output logic             last_row
);

	logic [1:0]                    row_q;
	logic                          strobe_q;
	logic [1:0]                    row_num_q;
	logic                          last_q;
	dxt1_pkg::texel_t [3:0]        texel_q;
	dxt1_pkg::texel_t [3:0]        texel_d;
	dxt1_pkg::row_idx_t            bits;
	logic                          emit;

	assign emit  = ~q_empty;
	assign q_pop = emit & (row_q == dxt1_pkg::LAST_ROW);

	always_comb begin
		bits = head_word.idx[row_q];
		for (int c = 0; c < 4; c++) begin
			texel_d[c] = head_word.pal[bits[7 - 2 * c -: 2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (emit) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_num_q <= row_q;
			last_q    <= row_q == dxt1_pkg::LAST_ROW;
			texel_q   <= texel_d;
		end
	end

	assign strobe       = strobe_q;
	assign row_number   = row_num_q;
	assign last_row     = last_q;
	assign texel_left   = texel_q[0];
	assign texel_second = texel_q[1];
	assign texel_third  = texel_q[2];
	assign texel_right  = texel_q[3];

`ifndef SYNTHESIS
	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && row_number != 2'd0) |-> ($past(strobe) && $past(row_number) == row_number - 2'd1))
		else $error("row word out of order");
	a_last_on_row3: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last_row == (row_number == dxt1_pkg::LAST_ROW)))
		else $error("last row flag mismatch");
	a_pop_at_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (strobe && last_row)) else $error("block popped before its last row");
`endif

endmodule

/* tb/dxt1_row_checker.sv */
// row word checker for the dxt1 block texel decoder: predicts each block's rows and compares
module dxt1_row_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] first_color,
	input  logic [15:0] second_color,
	input  logic [7:0]  row_zero_indices,
	input  logic [7:0]  row_one_indices,
	input  logic [7:0]  row_two_indices,
	input  logic [7:0]  row_three_indices,
	input  logic        strobe,
	input  logic [1:0]  row_number,
	input  logic [31:0] texel_left,
	input  logic [31:0] texel_second,
	input  logic [31:0] texel_third,
	input  logic [31:0] texel_right,
	input  logic        last_row,
	output int          fail_count,
	output int          rows_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef dxt1_pkg::texel_t [3:0] palette_t;

	typedef struct packed {
		logic [dxt1_pkg::ROW_NUM_W-1:0] row;
		dxt1_pkg::texel_t [3:0]         texel;
		logic                           last;
	} row_word_t;

	row_word_t expected_rows [$];

	initial fail_count = 0;
	initial rows_pending = 0;

	function automatic logic [7:0] expand5(logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] expand6(logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	function automatic palette_t build_palette(logic [15:0] c0, logic [15:0] c1);
		logic [7:0] e0 [3];
		logic [7:0] e1 [3];
		logic [7:0] mid [3];
		logic [7:0] far [3];
		int k;
		palette_t p;
		e0[0] = expand5(c0[15:11]);
		e0[1] = expand6(c0[10:5]);
		e0[2] = expand5(c0[4:0]);
		e1[0] = expand5(c1[15:11]);
		e1[1] = expand6(c1[10:5]);
		e1[2] = expand5(c1[4:0]);
		for (int ch = 0; ch < 3; ch++) begin
			if (c0 > c1) begin
				k = ((int'(e1[ch]) - int'(e0[ch])) >>> 1) - ((int'(e1[ch]) - int'(e0[ch])) >>> 3);
				mid[ch] = 8'(int'(e0[ch]) + k);
				far[ch] = 8'(int'(e1[ch]) - k);
			end else begin
				mid[ch] = 8'((int'(e0[ch]) + int'(e1[ch]) + 1) >> 1);
				far[ch] = e1[ch];
			end
		end
		p[0] = {dxt1_pkg::ALPHA_OPAQUE, e0[0], e0[1], e0[2]};
		p[1] = {dxt1_pkg::ALPHA_OPAQUE, e1[0], e1[1], e1[2]};
		p[2] = {dxt1_pkg::ALPHA_OPAQUE, mid[0], mid[1], mid[2]};
		p[3] = {(c0 > c1) ? dxt1_pkg::ALPHA_OPAQUE : dxt1_pkg::ALPHA_CLEAR,
			far[0], far[1], far[2]};
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin : watch
		row_word_t w;
		palette_t p;
		dxt1_pkg::row_idx_t idx [4];
		if (!arst_n) begin
			expected_rows.delete();
			rows_pending <= 0;
		end else begin
			if (strobe) begin
				if (expected_rows.size() == 0) begin
					report_mismatch("row word with none expected", {30'd0, row_number}, 32'd0);
				end else begin
					w = expected_rows.pop_front();
					if (row_number !== w.row)
						report_mismatch("row_number", {30'd0, row_number}, {30'd0, w.row});
					if (texel_left !== w.texel[0])
						report_mismatch("texel_left", texel_left, w.texel[0]);
					if (texel_second !== w.texel[1])
						report_mismatch("texel_second", texel_second, w.texel[1]);
					if (texel_third !== w.texel[2])
						report_mismatch("texel_third", texel_third, w.texel[2]);
					if (texel_right !== w.texel[3])
						report_mismatch("texel_right", texel_right, w.texel[3]);
					if (last_row !== w.last)
						report_mismatch("last_row", {31'd0, last_row}, {31'd0, w.last});
				end
			end
			if (start && !busy) begin
				p = build_palette(first_color, second_color);
				idx[0] = row_zero_indices;
				idx[1] = row_one_indices;
				idx[2] = row_two_indices;
				idx[3] = row_three_indices;
				for (int r = 0; r < dxt1_pkg::ROWS; r++) begin
					w.row = r[dxt1_pkg::ROW_NUM_W-1:0];
					for (int c = 0; c < dxt1_pkg::COLS; c++)
						w.texel[c] = p[idx[r][7-2*c -: 2]];
					w.last = (w.row == dxt1_pkg::LAST_ROW);
					expected_rows.push_back(w);
				end
			end
			rows_pending <= expected_rows.size();
		end
	end

endmodule

/* tb/tb_dxt1_block_texel_decoder.sv */
// testbench top of the dxt1 block texel decoder: block stimulus, timeout and verdict
module tb_dxt1_block_texel_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BLOCKS = 370;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] first_color = '0;
	logic [15:0] second_color = '0;
	logic [7:0]  row_zero_indices = '0;
	logic [7:0]  row_one_indices = '0;
	logic [7:0]  row_two_indices = '0;
	logic [7:0]  row_three_indices = '0;
	logic        strobe;
	logic [1:0]  row_number;
	logic [31:0] texel_left;
	logic [31:0] texel_second;
	logic [31:0] texel_third;
	logic [31:0] texel_right;
	logic        last_row;
	int          fail_count;
	int          rows_pending;
	int          cycles = 0;

	dxt1_block_texel_decoder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_color(first_color), .second_color(second_color),
		.row_zero_indices(row_zero_indices), .row_one_indices(row_one_indices),
		.row_two_indices(row_two_indices), .row_three_indices(row_three_indices),
		.strobe(strobe), .row_number(row_number),
		.texel_left(texel_left), .texel_second(texel_second),
		.texel_third(texel_third), .texel_right(texel_right),
		.last_row(last_row)
	);

	dxt1_row_checker rows_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_color(first_color), .second_color(second_color),
		.row_zero_indices(row_zero_indices), .row_one_indices(row_one_indices),
		.row_two_indices(row_two_indices), .row_three_indices(row_three_indices),
		.strobe(strobe), .row_number(row_number),
		.texel_left(texel_left), .texel_second(texel_second),
		.texel_third(texel_third), .texel_right(texel_right),
		.last_row(last_row), .fail_count(fail_count), .rows_pending(rows_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
			input logic [7:0] i0, input logic [7:0] i1, input logic [7:0] i2,
			input logic [7:0] i3, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		first_color <= c0;
		second_color <= c1;
		row_zero_indices <= i0;
		row_one_indices <= i1;
		row_two_indices <= i2;
		row_three_indices <= i3;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] extreme_colour();
		return {$urandom_range(0, 1) ? 5'h1F : 5'h00, $urandom_range(0, 1) ? 6'h3F : 6'h00,
			$urandom_range(0, 1) ? 5'h1F : 5'h00};
	endfunction

	function automatic logic [7:0] pattern_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'h55;
			2: return 8'hAA;
			3: return 8'hFF;
			4: return 8'hE4;
			default: return 8'h1B;
		endcase
	endfunction

	initial begin
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] tmp;
		logic [7:0]  ib [4];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// equal endpoints, all zero and all one
		send_block(16'h0000, 16'h0000, 8'h00, 8'h55, 8'hAA, 8'hFF, 1'b0);
		send_block(16'hFFFF, 16'hFFFF, 8'hE4, 8'h1B, 8'hFF, 8'h00, 1'b0);
		// widest spans in both compare modes
		send_block(16'hFFFF, 16'h0000, 8'hE4, 8'h1B, 8'h55, 8'hAA, 1'b0);
		send_block(16'h0000, 16'hFFFF, 8'hE4, 8'h1B, 8'h55, 8'hAA, 1'b1);
		// one channel at a time
		send_block(16'hF800, 16'h0000, 8'hE4, 8'hE4, 8'hE4, 8'hE4, 1'b1);
		send_block(16'h07E0, 16'h001F, 8'hE4, 8'h1B, 8'hE4, 8'h1B, 1'b0);
		send_block(16'h001F, 16'h07E0, 8'hE4, 8'h1B, 8'hE4, 8'h1B, 1'b0);
		send_block(16'h0000, 16'hF800, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		// compare decided by one step, then equal endpoints
		send_block(16'h8001, 16'h8000, 8'hE4, 8'h39, 8'h93, 8'h4E, 1'b0);
		send_block(16'h8000, 16'h8001, 8'hE4, 8'h39, 8'h93, 8'h4E, 1'b1);
		send_block(16'h1234, 16'h1234, 8'hFF, 8'hAA, 8'h55, 8'h00, 1'b0);
		// channels falling and rising in both compare modes
		send_block(16'hF81F, 16'h07E0, 8'hE4, 8'h1B, 8'h72, 8'h8D, 1'b0);
		send_block(16'h841F, 16'h7BE0, 8'hE4, 8'h1B, 8'h72, 8'h8D, 1'b1);
		send_block(16'h7BEF, 16'h0821, 8'hAA, 8'hFF, 8'h55, 8'hE4, 1'b0);
		send_block(16'h0821, 16'h7BEF, 8'hAA, 8'hFF, 8'h55, 8'hE4, 1'b0);
		send_block(16'hAAAA, 16'h5555, 8'hE4, 8'hE4, 8'h1B, 8'h1B, 1'b1);
		send_block(16'h5555, 16'hAAAA, 8'hE4, 8'hE4, 8'h1B, 8'h1B, 1'b1);
		send_block(16'hFFFE, 16'h0001, 8'h00, 8'h55, 8'hAA, 8'hFF, 1'b0);
		wait_drained();

		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			c0 = 16'($urandom());
			c1 = 16'($urandom());
			for (int r = 0; r < 4; r++) ib[r] = 8'($urandom());
			case ($urandom_range(0, 9))
				5: c1 = c0;
				6: c1 = c0 + 16'($urandom_range(0, 2)) - 16'd1;
				7: begin
					c0 = extreme_colour();
					c1 = extreme_colour();
				end
				8: for (int r = 0; r < 4; r++) ib[r] = pattern_byte();
				9: if (c0 > c1) begin
					tmp = c0;
					c0 = c1;
					c1 = tmp;
				end
				default: ;
			endcase
			send_block(c0, c1, ib[0], ib[1], ib[2], ib[3], (n % 60) < 20);
			if (n == RANDOM_BLOCKS / 2) wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && rows_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
